[src/nafir_pkg.sv]
// shared types and constants of the normalised lms adaptive fir
// no dependencies; imported by every module of the block
package nafir_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 32;
  localparam int NUM_W    = 58;  // magnitude of step * error * 2^28
  localparam int G_W      = 60;  // signed gain, split into two halves for the multiplier
  localparam int G_HALF   = 30;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MU             = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGULARIZATION = 2'd2;

  // reset values of the configuration registers
  localparam logic [5:0]  TAP_COUNT_RST = 6'd32;
  localparam logic [14:0] MU_RST        = 15'd8192;
  localparam logic [31:0] DEFAULT_REG   = 32'd1074;  // about 1e-6 in q2.30

  // request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_MAC,
    ST_MAC_WAIT,
    ST_DIV,
    ST_UPD,
    ST_UPD_WAIT
  } nafir_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic clear;
    logic wr_sample;
    logic rd_issue;
    logic rd_upd;
    logic div_start;
    logic finish;
  } nafir_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic pipe_empty;
    logic last_tap;
    logic div_done;
    logic out_free;
  } nafir_stat_t;

endpackage

[src/nafir_div.sv]
// restoring unsigned divider, one quotient bit per cycle
// depends on nafir_pkg for the dividend width
module nafir_div import nafir_pkg::*; #(
  parameter int DEN_W = 36
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             qbit;

  // one restoring step
  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], qbit};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // operands, remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[src/nafir_ctrl.sv]
// controller state machine sequencing the filter and update passes
// depends on nafir_pkg for the state, command and status types
module nafir_ctrl import nafir_pkg::*; #(
  parameter int CNT_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_kind,
  output logic             in_tready,
  input  nafir_stat_t      stat,
  output nafir_cmd_t       cmd,
  output logic [CNT_W-1:0] tap_idx
);

  nafir_state_t     state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_kind == REQ_CLEAR) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        cmd.wr_sample = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_MAC;
      end
      ST_MAC: begin
        cmd.rd_issue = 1'b1;
        if (stat.last_tap) begin
          state_nxt = ST_MAC_WAIT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_MAC_WAIT: begin
        if (stat.pipe_empty) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cnt_nxt   = '0;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.rd_issue = 1'b1;
        cmd.rd_upd   = 1'b1;
        if (stat.last_tap) begin
          state_nxt = ST_UPD_WAIT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_UPD_WAIT: begin
        if (stat.pipe_empty && stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign tap_idx = cnt_r;

endmodule

[src/nafir_dp.sv]
// datapath: config registers, delay line and weight memories, mac pipeline,
// error and gain arithmetic, output register; uses nafir_pkg and nafir_div
module nafir_dp import nafir_pkg::*; #(
  parameter int MAX_TAPS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  nafir_cmd_t           cmd,
  output nafir_stat_t          stat,
  input  logic [$clog2(MAX_TAPS+1)-1:0] tap_idx,
  input  logic [2*SAMPLE_W-1:0] in_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2*SAMPLE_W-1:0] out_data
);

  localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int ACC_W = 48 + $clog2(MAX_TAPS);
  localparam int ENG_W = 31 + $clog2(MAX_TAPS);
  localparam int DEN_W = ENG_W + 1;
  localparam int EST_W = ACC_W - 27;
  localparam int ERR_W = EST_W + 1;
  localparam logic [8:0] MAX9 = 9'(MAX_TAPS);

  // configuration registers
  logic [5:0]  tap_r;
  logic [14:0] step_r;
  logic [31:0] reg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r  <= TAP_COUNT_RST;
      step_r <= MU_RST;
      reg_r  <= DEFAULT_REG;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TAP_COUNT:      tap_r  <= cfg_data[5:0];
        CFG_MU:             step_r <= cfg_data[14:0];
        CFG_REGULARIZATION: reg_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective tap count, used for the last-tap flag
  logic [CNT_W-1:0] n_eff;
  always_comb begin
    if (tap_r == 6'd0)
      n_eff = CNT_W'(1);
    else if ({3'b0, tap_r} > MAX9)
      n_eff = CNT_W'(MAX_TAPS);
    else
      n_eff = CNT_W'(tap_r);
  end

  // captured request
  logic signed [SAMPLE_W-1:0] samp_r, des_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      samp_r <= in_data[SAMPLE_W-1:0];
      des_r  <= in_data[2*SAMPLE_W-1:SAMPLE_W];
    end
  end

  // write index
  logic [IDX_W-1:0] wi_r;
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear)
      wi_r <= '0;
    else if (cmd.finish)
      wi_r <= (wi_r == IDX_W'(MAX_TAPS - 1)) ? '0 : wi_r + IDX_W'(1);
  end

  // read addresses: newest sample first
  logic [IDX_W-1:0] w_addr, x_addr;
  logic [IDX_W:0]   x_diff;
  always_comb begin
    w_addr = tap_idx[IDX_W-1:0];
    x_diff = {1'b0, wi_r} - {1'b0, w_addr};
    if (wi_r < w_addr)
      x_diff = x_diff + (IDX_W+1)'(MAX_TAPS);
    x_addr = x_diff[IDX_W-1:0];
  end

  // memories and their valid bits
  logic signed [SAMPLE_W-1:0] dmem [MAX_TAPS];
  logic signed [WEIGHT_W-1:0] wmem [MAX_TAPS];
  logic [MAX_TAPS-1:0]        dv_r, wv_r;
  logic signed [SAMPLE_W-1:0] xrd_r;
  logic signed [WEIGHT_W-1:0] wrd_r;
  logic                       w_commit;
  logic [IDX_W-1:0]           s2_idx_r;
  logic signed [WEIGHT_W-1:0] w_sat;

  always_ff @(posedge clk) begin
    if (cmd.wr_sample)
      dmem[wi_r] <= samp_r;
    if (cmd.rd_issue)
      xrd_r <= dmem[x_addr];
  end

  always_ff @(posedge clk) begin
    if (w_commit)
      wmem[s2_idx_r] <= w_sat;
    if (cmd.rd_issue)
      wrd_r <= wmem[w_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      dv_r <= '0;
      wv_r <= '0;
    end else begin
      if (cmd.wr_sample)
        dv_r[wi_r] <= 1'b1;
      if (w_commit)
        wv_r[s2_idx_r] <= 1'b1;
    end
  end

  // stage one: read data
  logic             s1_v_r, s1_upd_r, s1_xv_r, s1_wv_r;
  logic [IDX_W-1:0] s1_idx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.rd_issue;
    end
    s1_upd_r <= cmd.rd_upd;
    s1_idx_r <= w_addr;
    s1_xv_r  <= dv_r[x_addr];
    s1_wv_r  <= wv_r[w_addr];
  end

  logic signed [SAMPLE_W-1:0] x1;
  logic signed [WEIGHT_W-1:0] w1;
  assign x1 = s1_xv_r ? xrd_r : '0;
  assign w1 = s1_wv_r ? wrd_r : '0;

  // stage two: products
  logic signed [G_W-1:0]      g_r;
  logic                       s2_v_r, s2_upd_r;
  logic signed [47:0]         pa_r;
  logic [30:0]                pe_r;
  logic signed [46:0]         plo_r;
  logic signed [45:0]         phi_r;
  logic signed [WEIGHT_W-1:0] w2_r;
  logic signed [31:0]         sq;

  assign sq = x1 * x1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_upd_r <= s1_upd_r;
    s2_idx_r <= s1_idx_r;
    w2_r     <= w1;
    pa_r     <= w1 * x1;
    pe_r     <= sq[30:0];
    plo_r    <= $signed({1'b0, g_r[G_HALF-1:0]}) * x1;
    phi_r    <= $signed(g_r[G_W-1:G_HALF]) * x1;
  end

  // stage three: accumulate or update the weight
  logic signed [ACC_W-1:0] acc_r;
  logic [ENG_W-1:0]        eng_r;
  logic signed [75:0]      gx;
  logic signed [60:0]      delta;
  logic signed [62:0]      wsum;

  always_comb begin
    gx    = $signed({phi_r, 30'b0}) + 76'(plo_r);
    delta = gx[75:15];
    wsum  = 63'(w2_r) + 63'(delta);
    if (wsum > 63'sd2147483647)
      w_sat = 32'sh7fffffff;
    else if (wsum < -63'sd2147483648)
      w_sat = 32'sh80000000;
    else
      w_sat = wsum[31:0];
    w_commit = s2_v_r && s2_upd_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc_r <= '0;
      eng_r <= '0;
    end else if (s2_v_r && !s2_upd_r) begin
      acc_r <= acc_r + ACC_W'(pa_r);
      eng_r <= eng_r + ENG_W'(pe_r);
    end
  end

  // estimate, error and gain numerator
  logic signed [EST_W-1:0]    est_full;
  logic signed [ERR_W-1:0]    err_full;
  logic signed [SAMPLE_W-1:0] est16, err16;
  logic [SAMPLE_W-1:0]        err_mag;
  logic [30:0]                step_err;
  logic [NUM_W-1:0]           num;
  logic [DEN_W-1:0]           den;
  logic [31:0]                reg_eff;

  always_comb begin
    est_full = acc_r[ACC_W-1:27];
    err_full = ERR_W'(des_r) - ERR_W'(est_full);
    if (est_full > EST_W'(32767))
      est16 = 16'sh7fff;
    else if (est_full < -EST_W'(32768))
      est16 = 16'sh8000;
    else
      est16 = est_full[SAMPLE_W-1:0];
    if (err_full > ERR_W'(32767))
      err16 = 16'sh7fff;
    else if (err_full < -ERR_W'(32768))
      err16 = 16'sh8000;
    else
      err16 = err_full[SAMPLE_W-1:0];
    err_mag  = err16[SAMPLE_W-1] ? 16'(-err16) : err16;
    step_err = step_r * err_mag;
    num      = {step_err[29:0], 28'b0};
    reg_eff  = (reg_r == 32'd0) ? DEFAULT_REG : reg_r;
    den      = DEN_W'(eng_r) + DEN_W'(reg_eff);
  end

  // result held for the output and sign of the gain
  logic signed [SAMPLE_W-1:0] est_r, err_r;
  logic                       neg_r;
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      est_r <= est16;
      err_r <= err16;
      neg_r <= err16[SAMPLE_W-1];
    end
  end

  // gain division
  logic             div_done;
  logic [NUM_W-1:0] quo;

  nafir_div #(.DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  // signed gain, stable while the quotient is held
  always_ff @(posedge clk) begin
    g_r <= neg_r ? -$signed({2'b0, quo}) : $signed({2'b0, quo});
  end

  // output register
  logic                  out_valid_r;
  logic [2*SAMPLE_W-1:0] out_data_r;
  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (cmd.finish)
      out_valid_r <= 1'b1;
    else if (out_ready)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish)
      out_data_r <= {est_r, err_r};
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status
  always_comb begin
    stat.pipe_empty = !s1_v_r && !s2_v_r;
    stat.last_tap   = (tap_idx == n_eff - CNT_W'(1));
    stat.div_done   = div_done;
    stat.out_free   = !out_valid_r || out_ready;
  end

endmodule

[src/nlms_adaptive_fir.sv]
// normalised lms adaptive fir filter, top level
// depends on nafir_pkg, nafir_ctrl, nafir_dp and nafir_div
//
// usage: each request on the in_ stream is either a sample pair (tuser low)
// or a clear (tuser high). a sample pair gives one result on the out_ stream:
// the saturated a priori error and estimate. a clear zeroes the weights, the
// delay line and the write index and gives no result.
// the cfg_ channel writes tap_count (0), the adaptation step (1) and
// regularization (2); it is always ready and is to be written only while
// idle, which the user must keep to: the block does not enforce it.
// requests are handled one at a time. a sample pair runs a filter pass, a
// restoring divider for the normalised gain and an update pass; each pass
// goes one tap per cycle over the n taps in use through a three-stage
// multiply pipeline. a clear keeps the block idle and ready. the result is
// valid in the same cycle as the block is idle again for the next request.
// the result waits in an output register; if the receiver stalls, the block
// holds the next result back until the earlier one is taken.
// reset: synchronous, active low; weights, delay line and index read as zero,
// registers return to 32 taps, step 8192 and regularization 1074.
module nlms_adaptive_fir import nafir_pkg::*; #(
  parameter int MAX_TAPS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // sample [15:0], desired [31:16]
  input  logic                 in_tuser,   // req_type
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // error [15:0], estimate [31:16]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int CNT_W = $clog2(MAX_TAPS + 1);

  nafir_cmd_t       cmd;
  nafir_stat_t      stat;
  logic [CNT_W-1:0] tap_idx;

  assign cfg_ready = 1'b1;

  // sequencing
  nafir_ctrl #(.CNT_W(CNT_W)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd),
    .tap_idx   (tap_idx)
  );

  // arithmetic and storage
  nafir_dp #(.MAX_TAPS(MAX_TAPS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .tap_idx   (tap_idx),
    .in_data   (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
